FILE: rtl/afr_pkg.sv
package afr_pkg;

    localparam int unsigned OUTPUT_RATE = 44100;
    localparam int unsigned MAX_OUT     = 6;
    localparam int unsigned RATE_W      = 18;
    localparam int unsigned NUM_W       = 19;

    typedef enum logic [1:0] {
        FMT_PCM16   = 2'd0,
        FMT_FLOAT32 = 2'd1,
        FMT_NONE2   = 2'd2,
        FMT_NONE3   = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        REG_IN_FORMAT   = 2'd0,
        REG_IN_RATE     = 2'd1,
        REG_IN_CHANNELS = 2'd2,
        REG_NONE        = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] chan0_word;
        logic [31:0] chan1_word;
        logic        silent;
        logic        packet_end;
    } src_item_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               last_of_run;
    } res_item_t;

    // Single precision product with 32767, rounded to nearest even,
    // truncated toward zero and saturated to 16 bits.
    function automatic logic signed [15:0] float_to_s16(input logic [31:0] b);
        logic        sgn;
        logic [7:0]  ex;
        logic [23:0] man;
        logic [38:0] prod;
        logic [23:0] q;
        logic        guard;
        logic        sticky;
        logic        lsb;
        logic [24:0] qr;
        logic [7:0]  sh;
        logic [16:0] ip;
        logic [24:0] shifted;
        logic signed [15:0] res;
        sgn  = b[31];
        ex   = b[30:23];
        man  = {1'b1, b[22:0]};
        prod = {man, 15'd0} - {15'd0, man};
        if (prod[38])
        begin
            q      = prod[38:15];
            guard  = prod[14];
            sticky = |prod[13:0];
            lsb    = prod[15];
            sh     = 8'd135 - ex;
        end
        else
        begin
            q      = prod[37:14];
            guard  = prod[13];
            sticky = |prod[12:0];
            lsb    = prod[14];
            sh     = 8'd136 - ex;
        end
        qr = {1'b0, q} + {24'd0, guard & (sticky | lsb)};
        shifted = qr >> sh[4:0];
        if (sh >= 8'd25)
            ip = 17'd0;
        else
            ip = shifted[16:0];
        if (ex == 8'd255 && b[22:0] != 23'd0)
            res = 16'sd0;
        else if (ex >= 8'd128)
            res = sgn ? -16'sd32768 : 16'sd32767;
        else if (ex == 8'd0)
            res = 16'sd0;
        else if (!sgn)
            res = (ip >= 17'd32767) ? 16'sd32767 : $signed(ip[15:0]);
        else
            res = (ip >= 17'd32768) ? -16'sd32768 : $signed(16'd0 - ip[15:0]);
        return res;
    endfunction

    function automatic logic signed [15:0] pcm_scaled(input logic [31:0] w);
        logic signed [15:0] s;
        logic signed [15:0] res;
        s = $signed(w[15:0]);
        if (s > 16'sd0)
            res = s - 16'sd1;
        else if (s < 16'sd0)
            res = s + 16'sd1;
        else
            res = 16'sd0;
        return res;
    endfunction

endpackage

FILE: rtl/afr_div.sv
module afr_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [afr_pkg::NUM_W-1:0]         dividend,
    input  logic [afr_pkg::RATE_W-1:0]        divisor,
    output logic                              done,
    output logic [afr_pkg::NUM_W-1:0]         quotient,
    output logic [afr_pkg::RATE_W-1:0]        remainder
);

    localparam int unsigned CNT_W = $clog2(afr_pkg::NUM_W + 1);

    logic [afr_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [afr_pkg::RATE_W-1:0] rem_reg, rem_next;
    logic [afr_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [afr_pkg::RATE_W:0]   trial;
    logic                       fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, num_reg[afr_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CNT_W'(afr_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[afr_pkg::NUM_W-2:0], 1'b0};
            rem_next = fits ? afr_pkg::RATE_W'(trial - {1'b0, divisor})
                            : trial[afr_pkg::RATE_W-1:0];
            quo_next = {quo_reg[afr_pkg::NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: rtl/audio_frame_to_s16_stereo_resampler.sv
// Converts one input audio frame per transfer into zero to six 16-bit stereo
// frames at 44100 Hz. Float32 samples are scaled by 32767 with single
// precision rounding, truncated and saturated (NaN gives zero); PCM16 samples
// pass raw at 44100 Hz with one or two channels and are pulled one step toward
// zero otherwise. When the input rate differs from 44100 Hz a phase
// accumulator, restarted at each packet end, decides how many copies of the
// frame are sent; a silent frame is sent once as zeros. One frame at a time
// is processed: the two channels are converted one after the other through
// one shared converter, and when the rate differs and a frame may be due a
// bit-serial divider follows, one quotient bit per cycle. Output frames then
// leave one per cycle while the output side keeps up, and the block returns
// to its idle state, in which the next input transfer is taken. The last
// result stays in the output register while the next input transfer is
// already taken.
module audio_frame_to_s16_stereo_resampler (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  afr_pkg::src_item_t    src_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output afr_pkg::res_item_t    res_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [17:0]           cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    localparam logic [afr_pkg::RATE_W-1:0] ORATE = afr_pkg::RATE_W'(afr_pkg::OUTPUT_RATE);

    state_t                     state_reg, state_next;
    afr_pkg::fmt_t              fmt_reg;
    logic [afr_pkg::RATE_W-1:0] rate_reg;
    logic [3:0]                 chan_reg;
    logic [afr_pkg::RATE_W-1:0] acc_reg, acc_next;
    afr_pkg::src_item_t         item_reg;
    logic                       sel_reg, sel_next;
    logic signed [15:0]         left_reg, left_next;
    logic signed [15:0]         right_reg, right_next;
    logic [2:0]                 cnt_reg, cnt_next;
    logic                       res_valid_reg, res_valid_next;
    afr_pkg::res_item_t         res_data_reg, res_data_next;

    logic [afr_pkg::RATE_W-1:0] rate_eff;
    logic                       mono;
    logic                       matched;
    logic                       raw_pcm;
    logic [31:0]                word;
    logic signed [15:0]         conv;
    logic [afr_pkg::RATE_W:0]   acc_plus_rate;
    logic                       div_start;
    logic [afr_pkg::NUM_W-1:0]  div_num;
    logic                       div_done;
    logic [afr_pkg::NUM_W-1:0]  div_quo;
    logic [afr_pkg::RATE_W-1:0] div_rem;
    logic                       load_out;

    assign rate_eff = (rate_reg == '0) ? ORATE : rate_reg;
    assign mono     = (chan_reg == 4'd1);
    assign matched  = (rate_eff == ORATE);
    // Zero channels counts as two, so mono or stereo is zero, one or two here.
    assign raw_pcm  = matched && (chan_reg <= 4'd2);
    assign acc_plus_rate = {1'b0, acc_reg} + {1'b0, rate_eff};

    always_comb
    begin
        word = sel_reg ? item_reg.chan1_word : item_reg.chan0_word;
        case (fmt_reg)
            afr_pkg::FMT_FLOAT32: conv = afr_pkg::float_to_s16(word);
            afr_pkg::FMT_PCM16:   conv = raw_pcm ? $signed(word[15:0])
                                                 : afr_pkg::pcm_scaled(word);
            default:              conv = 16'sd0;
        endcase
        if (item_reg.silent)
            conv = 16'sd0;
    end

    assign load_out = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        sel_next       = sel_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        div_start      = 1'b0;
        div_num        = '0;

        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                sel_next = 1'b0;
                if (src_valid)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                sel_next = 1'b1;
                if (!sel_reg)
                    left_next = conv;
                else
                begin
                    right_next = mono ? left_reg : conv;
                    if (item_reg.silent || matched)
                    begin
                        cnt_next   = 3'd1;
                        state_next = ST_EMIT;
                        if (item_reg.packet_end)
                            acc_next = '0;
                    end
                    else if (item_reg.packet_end)
                    begin
                        acc_next = '0;
                        if (acc_plus_rate <= {1'b0, ORATE})
                        begin
                            // Floor division of what is left of the output period.
                            div_num    = afr_pkg::NUM_W'(ORATE - acc_reg);
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        else
                            state_next = ST_IDLE;
                    end
                    else if (acc_reg < ORATE)
                    begin
                        // Ceiling division: add the divisor less one first.
                        div_num    = afr_pkg::NUM_W'(ORATE - acc_reg)
                                   + afr_pkg::NUM_W'(rate_eff) - 1'b1;
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        acc_next   = acc_reg - ORATE;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    // The new phase is how far the last copy overshoots the period.
                    if (!item_reg.packet_end)
                        acc_next = rate_eff - 1'b1 - div_rem;
                    if (div_quo >= afr_pkg::NUM_W'(afr_pkg::MAX_OUT))
                        cnt_next = 3'(afr_pkg::MAX_OUT);
                    else
                        cnt_next = div_quo[2:0];
                    state_next = (div_quo == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    res_valid_next            = 1'b1;
                    res_data_next.left_out    = left_reg;
                    res_data_next.right_out   = right_reg;
                    res_data_next.last_of_run = (cnt_reg == 3'd1);
                    cnt_next                  = cnt_reg - 1'b1;
                    if (cnt_reg == 3'd1)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    afr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (rate_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fmt_reg       <= afr_pkg::FMT_PCM16;
            rate_reg      <= ORATE;
            chan_reg      <= 4'd2;
            acc_reg       <= '0;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (afr_pkg::reg_idx_t'(cfg_index))
                    afr_pkg::REG_IN_FORMAT:   fmt_reg  <= afr_pkg::fmt_t'(cfg_wdata[1:0]);
                    afr_pkg::REG_IN_RATE:     rate_reg <= cfg_wdata;
                    afr_pkg::REG_IN_CHANNELS: chan_reg <= cfg_wdata[3:0];
                    default:                  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && src_valid)
            item_reg <= src_data;
        left_reg     <= left_next;
        right_reg    <= right_next;
        res_data_reg <= res_data_next;
    end

    assign src_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

FILE: rtl/afr_checker.sv
module afr_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    input  logic               src_stall,
    input  logic               res_valid,
    input  logic               res_stall,
    input  afr_pkg::res_item_t res_data
);

    // A waiting result holds still.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // One frame at a time: a taken input closes the input side.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> src_stall)
        else $error("input taken while busy");

    // While a run is unfinished no new input is taken.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.last_of_run |-> src_stall)
        else $error("input open during a run");

    // A run that is not finished delivers its next frame at once.
    a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && !res_data.last_of_run |=> res_valid)
        else $error("gap inside a run");

endmodule

bind audio_frame_to_s16_stereo_resampler afr_checker u_afr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

FILE: tb/sv/tb_audio_frame_to_s16_stereo_resampler.sv
module tb_audio_frame_to_s16_stereo_resampler;

    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset, the two data channels and the register write port of the block.
    logic                clk;
    logic                rst_n;
    logic                src_valid;
    logic                src_stall;
    afr_pkg::src_item_t  src_data;
    logic                res_valid;
    logic                res_stall;
    afr_pkg::res_item_t  res_data;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [17:0]         cfg_wdata;

    audio_frame_to_s16_stereo_resampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // One row of the directed table. The configuration is part of the row, so
    // the table walks through formats, rates and channel counts. Where the
    // result is obvious (matched rate, so exactly one frame) the expected
    // samples are typed in and the predictor is bypassed.
    typedef struct {
        afr_pkg::fmt_t   fmt;
        logic [17:0]     rate;
        logic [3:0]      chans;
        logic [31:0]     w0;
        logic [31:0]     w1;
        bit              sil;
        bit              endp;
        bit              typed;
        logic signed [15:0] exp_l;
        logic signed [15:0] exp_r;
    } dir_row_t;

    // Shadow copy of the block's registers and its phase accumulator.
    afr_pkg::fmt_t cur_fmt;
    logic [17:0]   cur_rate;
    logic [3:0]    cur_chans;
    logic [17:0]   phase_acc;

    // Stereo frames still owed by the block, oldest first.
    afr_pkg::res_item_t frames_due[$];
    dir_row_t           dir_rows[$];

    int          fail_count = 0;
    int          frames_seen = 0;
    int          frames_sent;
    int          idle_mode;     // 0 none, 1 sender, 2 receiver, 3 both
    bit          use_typed;
    afr_pkg::res_item_t typed_frame;

    // Two-delay clock, period 2 ns.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Float32 to 16 bits: the product with 32767 is rounded to 24 significant
    // bits (nearest, ties to even), then truncated toward zero and saturated.
    function automatic logic signed [15:0] float_sample(input logic [31:0] b);
        longint unsigned prod;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned half;
        longint unsigned mag;
        int              drop;
        int              e2;
        if (b[30:23] == 8'hFF)
            return (b[22:0] != 0) ? 16'sd0 : (b[31] ? -16'sd32768 : 16'sd32767);
        if (b[30:23] == 8'h00)
            return 16'sd0;
        prod = longint'({1'b1, b[22:0]}) * 64'd32767;
        drop = prod[38] ? 15 : 14;
        q    = prod >> drop;
        rem  = prod & ((64'd1 << drop) - 1);
        half = 64'd1 << (drop - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 1;
        e2 = drop + int'(b[30:23]) - 150;
        if (e2 > 20)
            mag = 64'd1 << 40;
        else if (e2 >= 0)
            mag = q << e2;
        else if (e2 < -40)
            mag = 0;
        else
            mag = q >> (-e2);
        if (!b[31])
            return (mag >= 32767) ? 16'sd32767 : 16'(mag);
        return (mag >= 32768) ? -16'sd32768 : -16'(mag);
    endfunction

    // PCM16 sample moved one step toward zero.
    function automatic logic signed [15:0] pcm_toward_zero(input logic [31:0] w);
        logic signed [15:0] s;
        s = w[15:0];
        if (s > 0)
            return s - 16'sd1;
        if (s < 0)
            return s + 16'sd1;
        return 16'sd0;
    endfunction

    // Works out the frames one accepted input causes and queues them.
    task automatic predict_frames(input afr_pkg::src_item_t it);
        longint unsigned rate;
        longint unsigned acc;
        longint unsigned count;
        logic [3:0]      ch;
        bit              mono;
        bit              matched;
        logic signed [15:0] l;
        logic signed [15:0] r;
        afr_pkg::res_item_t fr;
        int              n;
        rate    = (cur_rate == 0) ? afr_pkg::OUTPUT_RATE : cur_rate;
        ch      = (cur_chans == 0) ? 4'd2 : cur_chans;
        mono    = (ch == 1);
        matched = (rate == afr_pkg::OUTPUT_RATE);
        l = 0;
        r = 0;
        acc = phase_acc;
        if (it.silent)
            count = 1;
        else
        begin
            if (cur_fmt == afr_pkg::FMT_FLOAT32)
            begin
                l = float_sample(it.chan0_word);
                r = mono ? l : float_sample(it.chan1_word);
            end
            else if (cur_fmt == afr_pkg::FMT_PCM16)
            begin
                if (matched && (ch == 1 || ch == 2))
                begin
                    l = it.chan0_word[15:0];
                    r = mono ? l : signed'(it.chan1_word[15:0]);
                end
                else
                begin
                    l = pcm_toward_zero(it.chan0_word);
                    r = mono ? l : pcm_toward_zero(it.chan1_word);
                end
            end
            if (matched)
                count = 1;
            else if (it.packet_end)
                count = (acc + rate <= afr_pkg::OUTPUT_RATE)
                      ? (afr_pkg::OUTPUT_RATE - acc) / rate : 0;
            else
            begin
                count = (acc < afr_pkg::OUTPUT_RATE)
                      ? (afr_pkg::OUTPUT_RATE - acc + rate - 1) / rate : 0;
                phase_acc = 18'(acc + count * rate - afr_pkg::OUTPUT_RATE);
            end
        end
        if (it.packet_end)
            phase_acc = 0;
        n = (count > afr_pkg::MAX_OUT) ? int'(afr_pkg::MAX_OUT) : int'(count);
        for (int k = 0; k < n; k++)
        begin
            fr.left_out    = l;
            fr.right_out   = r;
            fr.last_of_run = (k == n - 1);
            frames_due.push_back(fr);
        end
    endtask

    // Register write; both the block and the shadow copy take the value.
    task automatic write_reg(input afr_pkg::reg_idx_t idx, input logic [17:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            afr_pkg::REG_IN_FORMAT:   cur_fmt   = afr_pkg::fmt_t'(val[1:0]);
            afr_pkg::REG_IN_RATE:     cur_rate  = val;
            afr_pkg::REG_IN_CHANNELS: cur_chans = val[3:0];
            default: ;
        endcase
    endtask

    // Takes the input valid down, waits until every owed frame has arrived,
    // then lets the block finish any input that produces nothing while its
    // division is still running.
    task automatic drain();
        src_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_config(input afr_pkg::fmt_t f, input logic [17:0] rt,
                              input logic [3:0] ch);
        drain();
        write_reg(afr_pkg::REG_IN_FORMAT, 18'(f));
        write_reg(afr_pkg::REG_IN_RATE, rt);
        write_reg(afr_pkg::REG_IN_CHANNELS, 18'(ch));
    endtask

    // Sends one transfer, with random idle cycles before it in the sender
    // idle phases. The prediction is made at the accepting edge. The task
    // returns at the next falling edge, where the caller either offers the
    // next transfer or drains.
    task automatic send_frame(input afr_pkg::src_item_t it);
        while ((idle_mode == 1 && $urandom_range(99) < 82)
               || (idle_mode == 3 && $urandom_range(99) < 36))
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= it;
        do
            @(posedge clk);
        while (src_stall);
        if (use_typed)
            frames_due.push_back(typed_frame);
        else
            predict_frames(it);
        frames_sent++;
        @(negedge clk);
    endtask

    task automatic add_row(input afr_pkg::fmt_t f, input int rt, input int ch,
                           input logic [31:0] w0, input logic [31:0] w1,
                           input bit sil, input bit endp, input bit typed,
                           input int el, input int er);
        dir_row_t row;
        row.fmt = f;
        row.rate = 18'(rt);
        row.chans = 4'(ch);
        row.w0 = w0;
        row.w1 = w1;
        row.sil = sil;
        row.endp = endp;
        row.typed = typed;
        row.exp_l = 16'(el);
        row.exp_r = 16'(er);
        dir_rows.push_back(row);
    endtask

    // Random float bits: mostly magnitudes from 2^-27 to just under 8, sometimes any bits.
    function automatic logic [31:0] rand_float();
        if ($urandom_range(3) == 0)
            return $urandom;
        return {1'($urandom), 8'($urandom_range(100, 129)), 23'($urandom)};
    endfunction

    // The receiver stalls at random in the phases that ask for it.
    always @(negedge clk)
    begin
        if (idle_mode == 2)
            res_stall <= ($urandom_range(99) < 82);
        else if (idle_mode == 3)
            res_stall <= ($urandom_range(99) < 36);
        else
            res_stall <= 1'b0;
    end

    // Every result transfer is checked against the oldest owed frame.
    always @(posedge clk)
    begin
        afr_pkg::res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            frames_seen++;
            if (frames_due.size() == 0)
            begin
                $error("result transfer with no frame expected: %0d %0d %0b",
                       res_data.left_out, res_data.right_out, res_data.last_of_run);
                fail_count++;
            end
            else
            begin
                want = frames_due.pop_front();
                if (res_data.left_out !== want.left_out)
                begin
                    $error("left_out: expected %0d, got %0d", want.left_out,
                           res_data.left_out);
                    fail_count++;
                end
                if (res_data.right_out !== want.right_out)
                begin
                    $error("right_out: expected %0d, got %0d", want.right_out,
                           res_data.right_out);
                    fail_count++;
                end
                if (res_data.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                           res_data.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // Hard limit on the run time.
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        afr_pkg::src_item_t it;
        afr_pkg::fmt_t      f;
        int        pkt_len;
        int        sent;
        int        pick;
        logic [17:0] rt;
        rst_n      = 1'b0;
        src_valid  = 1'b0;
        src_data   = '0;
        cfg_we     = 1'b0;
        cfg_index  = afr_pkg::REG_IN_FORMAT;
        cfg_wdata  = '0;
        idle_mode  = 0;
        use_typed  = 0;
        frames_sent = 0;
        cur_fmt    = afr_pkg::FMT_PCM16;
        cur_rate   = 18'(afr_pkg::OUTPUT_RATE);
        cur_chans  = 4'd2;
        phase_acc  = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The first rows run on the reset configuration.
        add_row(afr_pkg::FMT_PCM16, afr_pkg::OUTPUT_RATE, 2, 32'h0000_8000, 32'h0000_7FFF,
                0, 0, 1, -32768, 32767);
        add_row(afr_pkg::FMT_PCM16, afr_pkg::OUTPUT_RATE, 2, 32'hFFFF_1234, 32'h0000_FFFF,
                0, 1, 1, 16'h1234, -1);
        add_row(afr_pkg::FMT_PCM16, afr_pkg::OUTPUT_RATE, 2, 32'hAAAA_5555, 32'h5555_AAAA,
                1, 1, 1, 0, 0);
        add_row(afr_pkg::FMT_PCM16, afr_pkg::OUTPUT_RATE, 1, 32'h0000_0005, 32'h0000_7777,
                0, 1, 1, 5, 5);
        add_row(afr_pkg::FMT_PCM16, 0, 0, 32'h0000_0123, 32'h0000_8001,
                0, 1, 1, 16'h0123, -32767);
        add_row(afr_pkg::FMT_PCM16, afr_pkg::OUTPUT_RATE, 8, 32'h0000_8000, 32'h0000_0001,
                0, 1, 1, -32767, 0);
        add_row(afr_pkg::FMT_FLOAT32, afr_pkg::OUTPUT_RATE, 2, 32'h7F80_0000, 32'hFF80_0000,
                0, 0, 1, 32767, -32768);
        add_row(afr_pkg::FMT_FLOAT32, afr_pkg::OUTPUT_RATE, 2, 32'h7FC0_0000, 32'hFFFF_FFFF,
                0, 0, 1, 0, 0);
        add_row(afr_pkg::FMT_FLOAT32, afr_pkg::OUTPUT_RATE, 2, 32'h3F80_0000, 32'hBF80_0000,
                0, 0, 1, 32767, -32767);
        add_row(afr_pkg::FMT_FLOAT32, afr_pkg::OUTPUT_RATE, 2, 32'h3F00_0000, 32'h0000_0001,
                0, 1, 1, 16383, 0);
        add_row(afr_pkg::FMT_FLOAT32, afr_pkg::OUTPUT_RATE, 2, 32'h7F7F_FFFF, 32'h8000_0000,
                0, 1, 0, 0, 0);
        add_row(afr_pkg::FMT_NONE3, afr_pkg::OUTPUT_RATE, 2, 32'h3F80_0000, 32'h0000_7FFF,
                0, 1, 1, 0, 0);
        // Lowest rate: many copies per frame, up to six, and a short last frame.
        add_row(afr_pkg::FMT_FLOAT32, 8000, 1, 32'h3E80_0000, 32'h0, 0, 0, 0, 0, 0);
        add_row(afr_pkg::FMT_FLOAT32, 8000, 1, 32'hBE80_0001, 32'h0, 0, 0, 0, 0, 0);
        add_row(afr_pkg::FMT_FLOAT32, 8000, 1, 32'h3F7F_FFFF, 32'h0, 1, 0, 0, 0, 0);
        add_row(afr_pkg::FMT_FLOAT32, 8000, 1, 32'hC000_0000, 32'h0, 0, 1, 0, 0, 0);
        // Above the output rate some frames give nothing at all.
        add_row(afr_pkg::FMT_PCM16, 192000, 2, 32'h0000_7FFF, 32'h0000_8000, 0, 0, 0, 0, 0);
        add_row(afr_pkg::FMT_PCM16, 192000, 2, 32'h0000_0001, 32'h0000_FFFF, 0, 0, 0, 0, 0);
        add_row(afr_pkg::FMT_PCM16, 192000, 2, 32'h0000_1111, 32'h0000_2222, 0, 0, 0, 0, 0);
        add_row(afr_pkg::FMT_PCM16, 192000, 2, 32'h0000_3333, 32'h0000_4444, 0, 1, 0, 0, 0);
        add_row(afr_pkg::FMT_NONE2, 22050, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(afr_pkg::FMT_NONE2, 22050, 2, 32'h1234_5678, 32'h8765_4321, 0, 1, 0, 0, 0);
        add_row(afr_pkg::FMT_PCM16, 18'h3FFFF, 4'hF, 32'h0000_8000, 32'h0000_7FFF,
                0, 1, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].fmt != cur_fmt || dir_rows[i].rate != cur_rate
                || dir_rows[i].chans != cur_chans)
                set_config(dir_rows[i].fmt, dir_rows[i].rate, dir_rows[i].chans);
            it.chan0_word = dir_rows[i].w0;
            it.chan1_word = dir_rows[i].w1;
            it.silent     = dir_rows[i].sil;
            it.packet_end = dir_rows[i].endp;
            use_typed = dir_rows[i].typed;
            typed_frame.left_out    = dir_rows[i].exp_l;
            typed_frame.right_out   = dir_rows[i].exp_r;
            typed_frame.last_of_run = 1'b1;
            send_frame(it);
        end
        use_typed = 0;

        // Random part: eight phases of packets, each with its own settings
        // and idling mode, covering every mode twice.
        for (int ph = 0; ph < 8; ph++)
        begin
            f    = afr_pkg::fmt_t'($urandom_range(3));
            pick = $urandom_range(5);
            case (pick)
                0: rt = 18'(afr_pkg::OUTPUT_RATE);
                1: rt = 18'd8000;
                2: rt = 18'd192000;
                3: rt = 18'd0;
                default: rt = 18'($urandom_range(8000, 192000));
            endcase
            set_config(f, rt, 4'($urandom_range(15)));
            idle_mode = ph % 4;
            sent = 0;
            while (sent < 25)
            begin
                pkt_len = $urandom_range(1, 8);
                it.silent = ($urandom_range(7) == 0);
                for (int k = 0; k < pkt_len; k++)
                begin
                    if (cur_fmt == afr_pkg::FMT_FLOAT32)
                    begin
                        it.chan0_word = rand_float();
                        it.chan1_word = rand_float();
                    end
                    else
                    begin
                        it.chan0_word = $urandom;
                        it.chan1_word = $urandom;
                    end
                    // A few packets end early or carry a stray end mark.
                    it.packet_end = (k == pkt_len - 1) || ($urandom_range(19) == 0);
                    send_frame(it);
                    sent++;
                end
            end
            idle_mode = 0;
        end

        drain();
        $display("Sent %0d input frames over directed and eight random phases;", frames_sent);
        $display("checked %0d output frames across formats, rates and stall patterns.",
                 frames_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/afr_pkg.sv
rtl/afr_div.sv
rtl/audio_frame_to_s16_stereo_resampler.sv
rtl/afr_checker.sv
tb/sv/tb_audio_frame_to_s16_stereo_resampler.sv
